// ===== src/shfr_pkg.sv =====
// Package for the sync-header frame receiver.
// Holds the frame constants and the beat type shared by all modules.
// No dependencies.
`default_nettype none

package shfr_pkg;

  // Frame delimiters and the legal message type range.
  localparam logic [7:0] HdrFirst  = 8'hAA;
  localparam logic [7:0] HdrSecond = 8'h55;
  localparam logic [7:0] TypeLow   = 8'hC0;
  localparam logic [7:0] TypeHigh  = 8'hC9;

  // Byte positions within a 16-byte frame.
  localparam int unsigned PosW = 4;
  localparam logic [PosW-1:0] PosHdr1    = 4'd0;
  localparam logic [PosW-1:0] PosHdr2    = 4'd1;
  localparam logic [PosW-1:0] PosType    = 4'd2;
  localparam logic [PosW-1:0] PosPayLo   = 4'd3;
  localparam logic [PosW-1:0] PosPayHi   = 4'd14;
  localparam logic [PosW-1:0] PosCheck   = 4'd15;

  // Twelve payload bytes.
  localparam int unsigned PayBytes = 12;
  localparam int unsigned PayW     = PayBytes * 8;

  // One registered input byte on its way to the parser.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } shfr_beat_t;

endpackage : shfr_pkg

`default_nettype wire

// ===== src/shfr_in_stage.sv =====
// Input register of the frame receiver.
// Depends on shfr_pkg for the beat type.
`default_nettype none

module shfr_in_stage
  import shfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       take,
  output shfr_beat_t      beat
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;

  // The register is free when empty or when its byte leaves this cycle.
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  // Control state is reset; the data byte is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_rx_byte;
    end
  end

  assign beat.valid = valid_r;
  assign beat.data  = data_r;

endmodule : shfr_in_stage

`default_nettype wire

// ===== src/shfr_parser.sv =====
// Frame parser: byte position, running sum, payload shift line and result register.
// Depends on shfr_pkg for frame constants and the beat type.
`default_nettype none

module shfr_parser
  import shfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire shfr_beat_t  beat,
  output logic             take,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_msg_type,
  output logic [31:0]      out_payload_head,
  output logic [63:0]      out_payload_tail,
  output logic             out_checksum_ok
);

  logic [PosW-1:0] pos_r,  pos_nxt;
  logic [7:0]      sum_r,  sum_nxt;
  logic [7:0]      type_r, type_nxt;
  logic [PayW-1:0] pay_r;
  logic            pay_shift;
  logic            emit;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_type_r;
  logic [PayW-1:0] out_pay_r;
  logic            out_ok_r;
  logic [7:0]      b;

  assign b = beat.data;

  // A byte is consumed whenever the result register can take a new transaction.
  assign take = beat.valid && (!out_valid_r || out_ready);

  // Next-state logic for one received byte.
  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    type_nxt  = type_r;
    pay_shift = 1'b0;
    emit      = 1'b0;
    if (take) begin
      case (pos_r)
        PosHdr1: begin
          if (b == HdrFirst) begin
            sum_nxt = b;
            pos_nxt = PosHdr2;
          end else begin
            sum_nxt = 8'd0;
            pos_nxt = PosHdr1;
          end
        end
        PosHdr2: begin
          if (b == HdrSecond) begin
            sum_nxt = sum_r + b;
            pos_nxt = PosType;
          end else begin
            sum_nxt = 8'd0;
            pos_nxt = PosHdr1;
          end
        end
        PosType: begin
          if (b inside {[TypeLow:TypeHigh]}) begin
            type_nxt = b;
            sum_nxt  = sum_r + b;
            pos_nxt  = PosPayLo;
          end else begin
            sum_nxt = 8'd0;
            pos_nxt = PosHdr1;
          end
        end
        PosCheck: begin
          emit    = 1'b1;
          sum_nxt = 8'd0;
          pos_nxt = PosHdr1;
        end
        default: begin
          // Payload bytes, positions three to fourteen.
          pay_shift = 1'b1;
          sum_nxt   = sum_r + b;
          pos_nxt   = pos_r + 4'd1;
        end
      endcase
    end
  end

  // The result register empties when taken and fills at a checksum byte.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= PosHdr1;
      sum_r       <= 8'd0;
      type_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      type_r      <= type_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload shift line: the first payload byte ends up in the top byte.
  always_ff @(posedge clk) begin
    if (pay_shift) begin
      pay_r <= {pay_r[PayW-9:0], b};
    end
  end

  // Result payload, loaded with the checksum byte.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_type_r <= type_r;
      out_pay_r  <= pay_r;
      out_ok_r   <= (b == sum_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_msg_type     = out_type_r;
  assign out_payload_head = out_pay_r[PayW-1 -: 32];
  assign out_payload_tail = out_pay_r[63:0];
  assign out_checksum_ok  = out_ok_r;

  // A new result only follows a checksum byte.
  a_emit_at_check: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (pos_r == PosCheck) && take)
    else $error("result produced away from the checksum byte");

  // Waiting for the first header byte always means an empty sum.
  a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == PosHdr1) |-> (sum_r == 8'd0))
    else $error("running sum not cleared at frame start");

  // A stalled result freezes the frame position.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(pos_r))
    else $error("frame advanced while result stalled");

  // Delivered type is always within the legal range.
  a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_type_r >= TypeLow) && (out_type_r <= TypeHigh))
    else $error("message type out of range");

endmodule : shfr_parser

`default_nettype wire

// ===== src/sync_header_frame_receiver_unit.sv =====
// Top level of the sync-header frame receiver.
// Depends on shfr_pkg, shfr_in_stage and shfr_parser.
//
//  Channel | Direction | Handshake            | Payload
//  in_     | input     | in_valid / in_ready   | in_rx_byte[7:0]
//  out_    | output    | out_valid / out_ready | out_msg_type, out_payload_head,
//          |           |                       | out_payload_tail, out_checksum_ok
//
// One byte is accepted per cycle unless a result waiting on out_ready stalls it;
// a frame result follows its checksum byte through the input, then the result register.
// Reset (rst_n low, synchronous) returns the receiver to awaiting a header.
// While a result waits on out_ready, one further byte is held in the input register.
// Payload bytes are kept in a shift line of twelve bytes.
`default_nettype none

module sync_header_frame_receiver_unit
  import shfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_msg_type,
  output logic [31:0]      out_payload_head,
  output logic [63:0]      out_payload_tail,
  output logic             out_checksum_ok
);

  shfr_beat_t beat;
  logic       take;

  shfr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .beat       (beat)
  );

  shfr_parser u_parser (
    .clk              (clk),
    .rst_n            (rst_n),
    .beat             (beat),
    .take             (take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_msg_type     (out_msg_type),
    .out_payload_head (out_payload_head),
    .out_payload_tail (out_payload_tail),
    .out_checksum_ok  (out_checksum_ok)
  );

endmodule : sync_header_frame_receiver_unit

`default_nettype wire

// ===== tb/sv/sync_header_frame_receiver_unit_test.sv =====
// Self-checking testbench for the sync-header frame receiver.
// Depends on shfr_pkg and sync_header_frame_receiver_unit;
// a scoreboard class predicts frame results.
`timescale 1ns / 100ps

module sync_header_frame_receiver_unit_test;
  import shfr_pkg::*;

  // One completed frame as the block reports it.
  typedef struct packed {
    logic [7:0]  msg_type;
    logic [31:0] head;
    logic [63:0] tail;
    logic        sum_ok;
  } frame_result_t;

  // Tracks the frame parser and holds the frame results still to arrive.
  class frame_scoreboard;
    logic [PosW-1:0] position;
    logic [7:0]      frame_sum;
    logic [7:0]      frame_type;
    logic [7:0]      pay_bytes [PayBytes];
    frame_result_t   frames_due [$];
    int              failures;

    function new();
      position   = PosHdr1;
      frame_sum  = 8'h00;
      frame_type = 8'h00;
      failures   = 0;
      foreach (pay_bytes[i]) pay_bytes[i] = 8'h00;
    endfunction

    function void restart();
      position  = PosHdr1;
      frame_sum = 8'h00;
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    // Advances the parser by one accepted byte.
    function void note_byte(logic [7:0] rx);
      frame_result_t res;
      if (position == PosHdr1) begin
        if (rx == HdrFirst) begin
          frame_sum = rx;
          position  = PosHdr2;
        end else begin
          restart();
        end
      end else if (position == PosHdr2) begin
        if (rx == HdrSecond) begin
          frame_sum = frame_sum + rx;
          position  = PosType;
        end else begin
          restart();
        end
      end else if (position == PosType) begin
        if (rx >= TypeLow && rx <= TypeHigh) begin
          frame_type = rx;
          frame_sum  = frame_sum + rx;
          position   = PosPayLo;
        end else begin
          restart();
        end
      end else if (position <= PosPayHi) begin
        pay_bytes[position - PosPayLo] = rx;
        frame_sum = frame_sum + rx;
        position  = position + 1'b1;
      end else begin
        // Checksum byte: the result is given whether or not the sum matches.
        res.msg_type = frame_type;
        res.head     = {pay_bytes[0], pay_bytes[1], pay_bytes[2], pay_bytes[3]};
        res.tail     = {pay_bytes[4], pay_bytes[5], pay_bytes[6], pay_bytes[7],
                        pay_bytes[8], pay_bytes[9], pay_bytes[10], pay_bytes[11]};
        res.sum_ok   = (rx == frame_sum);
        frames_due   = {frames_due, res};
        restart();
      end
    endfunction

    // Compares one accepted result with the oldest frame due.
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (frames_due.size() == 0) begin
        $display("%0t: result with no frame due: type %h head %h tail %h ok %b",
                 $time, got.msg_type, got.head, got.tail, got.sum_ok);
        failures++;
        return;
      end
      want = frames_due.pop_front();
      if (got.msg_type !== want.msg_type) begin
        $display("%0t: msg_type expected %h, got %h", $time, want.msg_type, got.msg_type);
        failures++;
      end
      if (got.head !== want.head) begin
        $display("%0t: payload_head expected %h, got %h", $time, want.head, got.head);
        failures++;
      end
      if (got.tail !== want.tail) begin
        $display("%0t: payload_tail expected %h, got %h", $time, want.tail, got.tail);
        failures++;
      end
      if (got.sum_ok !== want.sum_ok) begin
        $display("%0t: checksum_ok expected %b, got %b", $time, want.sum_ok, got.sum_ok);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_msg_type;
  logic [31:0] out_payload_head;
  logic [63:0] out_payload_tail;
  logic        out_checksum_ok;

  frame_scoreboard sb = new();
  logic [7:0]      byte_plan [$];
  int              send_idle = 15;
  int              recv_idle = 67;
  int              bytes_sent = 0;

  sync_header_frame_receiver_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_msg_type     (out_msg_type),
    .out_payload_head (out_payload_head),
    .out_payload_tail (out_payload_tail),
    .out_checksum_ok  (out_checksum_ok)
  );

  always #6 clk = ~clk;

  // The result side stalls at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Both channels are observed at the clock edge on which a transaction completes.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_rx_byte);
      if (out_valid && out_ready)
        sb.check_result({out_msg_type, out_payload_head, out_payload_tail, out_checksum_ok});
    end
  end

  // Appends one byte to the send plan.
  function void plan_byte(logic [7:0] rx);
    byte_plan = {byte_plan, rx};
  endfunction

  // Queues one complete frame, optionally with a corrupted checksum byte.
  function void plan_frame(logic [7:0] kind, logic [7:0] pay [PayBytes], bit bad_sum);
    logic [7:0] sum;
    sum = HdrFirst + HdrSecond + kind;
    plan_byte(HdrFirst);
    plan_byte(HdrSecond);
    plan_byte(kind);
    foreach (pay[i]) begin
      plan_byte(pay[i]);
      sum = sum + pay[i];
    end
    if (bad_sum) sum = sum + 8'($urandom_range(254) + 1);
    plan_byte(sum);
  endfunction

  // Sends every planned byte, idling before each one at the current rate.
  task automatic send_plan();
    logic [7:0] rx;
    while (byte_plan.size() > 0) begin
      rx = byte_plan.pop_front();
      while ($urandom_range(99) < send_idle) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid   <= 1'b1;
      in_rx_byte <= rx;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      bytes_sent++;
    end
    in_valid <= 1'b0;
  endtask

  // Mostly well-formed frames, with broken headers and noise mixed in.
  task automatic run_random(int target);
    logic [7:0] pay [PayBytes];
    logic [7:0] rx;
    int         pick;
    int         len;
    bit         saw_hdr;
    while (bytes_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        foreach (pay[i]) pay[i] = 8'($urandom_range(255));
        plan_frame(8'($urandom_range(TypeHigh, TypeLow)), pay, $urandom_range(99) < 25);
      end else if (pick < 82) begin
        plan_byte(HdrFirst);
        if ($urandom_range(1)) begin
          do rx = 8'($urandom_range(255)); while (rx == HdrSecond);
          plan_byte(rx);
        end else begin
          plan_byte(HdrSecond);
          if ($urandom_range(1))
            plan_byte(8'($urandom_range(TypeLow - 1, 0)));
          else
            plan_byte(8'($urandom_range(255, TypeHigh + 1)));
        end
      end else begin
        len = $urandom_range(6, 1);
        saw_hdr = 1'b0;
        repeat (len) begin
          rx = 8'($urandom_range(255));
          if (rx == HdrFirst) saw_hdr = 1'b1;
          plan_byte(rx);
        end
        // Noise may have opened a frame; zeros run it out or are dropped.
        if (saw_hdr) repeat (13) plan_byte(8'h00);
      end
      send_plan();
    end
  endtask

  initial begin
    logic [7:0] pay [PayBytes];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: bad first header, bad second header, re-entry of a header as
    // second byte, type just outside each end of the range.
    plan_byte(8'h00);
    plan_byte(HdrFirst);
    plan_byte(8'h54);
    plan_byte(HdrFirst);
    plan_byte(HdrFirst);
    plan_byte(HdrSecond);
    plan_byte(HdrFirst);
    plan_byte(HdrSecond);
    plan_byte(TypeLow - 8'd1);
    plan_byte(HdrFirst);
    plan_byte(HdrSecond);
    plan_byte(TypeHigh + 8'd1);
    // Lowest type with an all-zero payload and a good sum; highest type with
    // an all-ones payload and a wrong sum.
    foreach (pay[i]) pay[i] = 8'h00;
    plan_frame(TypeLow, pay, 1'b0);
    foreach (pay[i]) pay[i] = 8'hFF;
    plan_frame(TypeHigh, pay, 1'b1);
    send_plan();

    run_random(480);
    send_idle = 67;
    recv_idle = 15;
    run_random(940);
    send_idle = 0;
    recv_idle = 0;
    run_random(1400);

    // Drain, then allow for the result pipeline before the final check.
    while (sb.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d frame results never arrived", $time, sb.pending());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2_400_000;
    $display("Verification failed");
    $finish;
  end

endmodule
